FILE: hw/rtl/bab_pkg.sv
// shared types and constants for the bit array with unaligned byte access
package bab_pkg;

  // storage geometry
  localparam int CapBytes  = 256;
  localparam int CapBits   = CapBytes * 8;
  localparam int ByteAw    = $clog2(CapBytes);
  localparam int RowAw     = ByteAw - 1;
  localparam int RowDepth  = CapBytes / 2;
  localparam int IdxW      = 11;
  localparam int UsedW     = 12;

  localparam logic [UsedW-1:0] CapBitsU = UsedW'(CapBits);

  // operation codes
  typedef enum logic [2:0] {
    MODE_SET_BIT   = 3'd0,
    MODE_CLR_BIT   = 3'd1,
    MODE_RD_BIT    = 3'd2,
    MODE_WR_BYTE   = 3'd3,
    MODE_RD_BYTE   = 3'd4
  } mode_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_BAD_INDEX = 3'd2,
    ST_PAST_END  = 3'd3,
    ST_NO_ROOM   = 3'd4
  } status_t;

endpackage

FILE: hw/rtl/bit_array_byte_access.sv
// top level of the bit array with unaligned byte access
//
// Slave channel s_*: one transfer is one access. s_tuser carries the mode
// (set bit, clear bit, read bit, write byte, read byte); s_tdata carries
// bit_index and write_byte. Master channel m_*: exactly one result transfer
// per access, in order, carrying read_value, status and the used size.
// The store is two banks of 128 bytes (even and odd byte addresses), so a
// byte that straddles two stored bytes touches each bank once: one read
// port and one write port per bank.
// An access accepted on s_* is registered in the middle stage, where the
// store read data arrives, and then in the output register that drives m_*.
// Throughput: one access per cycle unless m_* stalls, since the read is
// issued at acceptance and the merged bytes are written back when the
// access moves to the output register; a one-entry bypass covers an access
// that follows a write to the same row.
// Reset clears the used size, the pipeline and the per-byte valid bits, so
// the store reads as all zero at once, with no clearing pass.
// When the receiver stalls, the output register holds its result, one more
// access may wait in the middle stage, and s_tready then drops.
module bit_array_byte_access (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // bit_index[10:0], write_byte[18:11], zero[23:19]
  input  logic [2:0]  s_tuser,   // mode[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // read_value[7:0], status[10:8], used_bits[22:11], zero[23]
  output logic [2:0]  m_tuser    // unused, zero
);

  localparam int RowAw = bab_pkg::RowAw;
  localparam int ByteAw = bab_pkg::ByteAw;
  localparam int Depth = bab_pkg::RowDepth;
  localparam int UsedW = bab_pkg::UsedW;

  // input field split
  logic [10:0]       in_idx;
  logic [7:0]        in_wb;
  logic [ByteAw-1:0] in_byte;
  logic [RowAw-1:0]  in_row_e;
  logic [RowAw-1:0]  in_row_o;
  logic              s_accept;

  assign in_idx   = s_tdata[10:0];
  assign in_wb    = s_tdata[18:11];
  assign in_byte  = in_idx[10:3];
  assign in_row_o = in_byte[ByteAw-1:1];
  assign in_row_e = in_byte[0] ? in_byte[ByteAw-1:1] + RowAw'(1) : in_byte[ByteAw-1:1];

  // storage and valid bits
  logic [7:0]       mem_e [Depth];
  logic [7:0]       mem_o [Depth];
  logic [Depth-1:0] vld_e;
  logic [Depth-1:0] vld_o;

  // middle stage
  logic             s1_valid;
  logic [2:0]       s1_mode;
  logic [10:0]      s1_idx;
  logic [7:0]       s1_wb;
  logic [RowAw-1:0] s1_row_e;
  logic [RowAw-1:0] s1_row_o;
  logic [7:0]       rd_e;
  logic [7:0]       rd_o;
  logic             s1_adv;

  // last write bypass
  logic             fwd_valid;
  logic [RowAw-1:0] fwd_row_e;
  logic [RowAw-1:0] fwd_row_o;
  logic [7:0]       fwd_e;
  logic [7:0]       fwd_o;

  // state
  logic [UsedW-1:0] used;
  logic [UsedW-1:0] used_next;

  // output register
  logic             out_valid;
  logic [7:0]       out_value;
  logic [2:0]       out_status;
  logic [UsedW-1:0] out_used;

  // handshake
  assign s1_adv   = s1_valid && (!out_valid || m_tready);
  assign s_tready = !s1_valid || s1_adv;
  assign s_accept = s_tvalid && s_tready;

  // current byte contents, bypass first then store
  logic [7:0]  cur_e;
  logic [7:0]  cur_o;
  logic [15:0] word;
  logic [15:0] word_new;
  logic [15:0] mask;
  logic [15:0] data;
  logic [15:0] shifted;
  logic [2:0]  off;
  logic        odd_first;
  logic [UsedW-1:0] idx_w;
  logic [UsedW-1:0] idx_p1;
  logic [UsedW-1:0] idx_p8;
  logic [7:0]  value;
  logic [2:0]  status;
  logic        do_write;

  always_comb begin
    cur_e = (fwd_valid && fwd_row_e == s1_row_e) ? fwd_e : (vld_e[s1_row_e] ? rd_e : 8'd0);
    cur_o = (fwd_valid && fwd_row_o == s1_row_o) ? fwd_o : (vld_o[s1_row_o] ? rd_o : 8'd0);
    odd_first = s1_idx[3];
    off = s1_idx[2:0];
    word = odd_first ? {cur_o, cur_e} : {cur_e, cur_o};
    shifted = word << off;
    idx_w  = {1'b0, s1_idx};
    idx_p1 = idx_w + UsedW'(1);
    idx_p8 = idx_w + UsedW'(8);
  end

  // access decode
  always_comb begin
    value     = 8'd0;
    status    = bab_pkg::ST_OK;
    used_next = used;
    do_write  = 1'b0;
    mask      = 16'h8000 >> off;
    data      = 16'h0000;
    unique case (s1_mode)
      bab_pkg::MODE_SET_BIT, bab_pkg::MODE_CLR_BIT: begin
        if (idx_p1 > bab_pkg::CapBitsU) begin
          status = bab_pkg::ST_NO_ROOM;
        end else begin
          do_write = 1'b1;
          if (idx_w >= used) used_next = idx_p1;
          data = (s1_mode == bab_pkg::MODE_SET_BIT) ? mask : 16'h0000;
        end
      end
      bab_pkg::MODE_RD_BIT: begin
        if (used == '0) begin
          status = bab_pkg::ST_EMPTY;
        end else if (idx_w >= used) begin
          status = bab_pkg::ST_BAD_INDEX;
        end else begin
          value = {7'd0, shifted[15]};
        end
      end
      bab_pkg::MODE_WR_BYTE: begin
        mask = 16'hFF00 >> off;
        data = {s1_wb, 8'h00} >> off;
        if (idx_p8 > bab_pkg::CapBitsU) begin
          status = bab_pkg::ST_NO_ROOM;
        end else begin
          do_write = 1'b1;
          if (used < idx_p8) used_next = idx_p8;
        end
      end
      bab_pkg::MODE_RD_BYTE: begin
        if (idx_w >= used) begin
          status = bab_pkg::ST_BAD_INDEX;
        end else if (idx_p8 > used) begin
          status = bab_pkg::ST_PAST_END;
        end else begin
          value = shifted[15:8];
        end
      end
      default: begin
      end
    endcase
    word_new = (word & ~mask) | data;
  end

  // bank view of merged bytes
  logic [7:0] new_e;
  logic [7:0] new_o;
  assign new_e = odd_first ? word_new[7:0] : word_new[15:8];
  assign new_o = odd_first ? word_new[15:8] : word_new[7:0];

  // memory read at acceptance, write back on advance
  always_ff @(posedge clk) begin
    if (s_accept) begin
      rd_e <= mem_e[in_row_e];
      rd_o <= mem_o[in_row_o];
    end
    if (s1_adv && do_write) begin
      mem_e[s1_row_e] <= new_e;
      mem_o[s1_row_o] <= new_o;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      fwd_valid <= 1'b0;
      used      <= '0;
      vld_e     <= '0;
      vld_o     <= '0;
    end else begin
      if (s_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      if (s1_adv && do_write) begin
        used             <= used_next;
        vld_e[s1_row_e]  <= 1'b1;
        vld_o[s1_row_o]  <= 1'b1;
        fwd_valid        <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_mode  <= s_tuser;
      s1_idx   <= in_idx;
      s1_wb    <= in_wb;
      s1_row_e <= in_row_e;
      s1_row_o <= in_row_o;
    end
    if (s1_adv && do_write) begin
      fwd_row_e <= s1_row_e;
      fwd_row_o <= s1_row_o;
      fwd_e     <= new_e;
      fwd_o     <= new_o;
    end
    if (s1_adv) begin
      out_value  <= value;
      out_status <= status;
      out_used   <= used_next;
    end
  end

  // result transfer
  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_used, out_status, out_value};
  assign m_tuser  = 3'd0;

endmodule
